@@ hdl/cosg_pkg.sv @@
// Shared types, constants, trig tables and helpers for the circle outline segment generator.
package cosg_pkg;

    // Polygon and fixed-point geometry
    localparam int SEGMENTS           = 48;
    localparam int TRIG_FRACTION_BITS = 15;
    localparam int TRIG_W             = TRIG_FRACTION_BITS + 2;
    localparam int SEG_IDX_W          = $clog2(SEGMENTS);
    localparam int SEG_CNT_W          = $clog2(SEGMENTS + 1);
    localparam int COORD_W            = 16;
    localparam int RADIUS_W           = 14;
    localparam int THICK_W            = 12;
    localparam int SUM_W              = COORD_W + 2;
    localparam int PROD_W             = TRIG_W + RADIUS_W + 1;

    // Angle generation (elaboration only)
    localparam logic [63:0] Q30_ONE        = 64'd1 << 30;
    localparam logic [63:0] PI_QUARTER_Q32 = 64'hC90FDAA2;
    localparam logic [63:0] ANGLE_DIV      = 64'(4 * SEGMENTS);
    localparam logic [63:0] SEG_COUNT      = 64'(SEGMENTS);

    // Minimum line width, 1/16 pixel
    localparam logic [THICK_W-1:0] THICK_MIN = THICK_W'(2);

    // Command kinds
    localparam logic CMD_CIRCLE = 1'b0;
    localparam logic CMD_LINE   = 1'b1;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_ENABLE    = 3'd0,
        CFG_OUTLINE   = 3'd1,
        CFG_RAINBOW   = 3'd2,
        CFG_RADIUS    = 3'd3,
        CFG_THICKNESS = 3'd4,
        CFG_COLOR     = 3'd5,
        CFG_HUE_STEP  = 3'd6
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HUE,
        S_START,
        S_MUL_X,
        S_SUM_X,
        S_SUM_Y,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } t_in_item;

    typedef struct packed {
        logic                       command_kind;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  delta_x;
        logic signed [COORD_W-1:0]  delta_y;
        logic [RADIUS_W-1:0]        draw_size;
        logic [31:0]                draw_color;
        logic                       last_command;
    } t_out_item;

    // Request into the shared point unit
    typedef struct packed {
        logic                       issue;
        logic signed [TRIG_W-1:0]   trig;
        logic signed [COORD_W-1:0]  center;
    } t_pt_req;

    // Saturate to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > SUM_W'(32767)) begin
            res = 16'sh7FFF;
        end else if (v < -SUM_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // Q30 Taylor series, truncating at each step
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
        return t;
    endfunction

    // Round half up from Q30 to the table precision
    function automatic logic signed [63:0] to_trig_bits(input logic [63:0] v);
        return $signed((v + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS));
    endfunction

    // Packed table of cos (want_sin = 0) or sin of k/SEGMENTS turn
    function automatic logic [SEGMENTS*TRIG_W-1:0] build_trig(input logic want_sin);
        logic [SEGMENTS*TRIG_W-1:0] tab;
        logic [63:0]                oct;
        logic [63:0]                rem;
        logic [63:0]                x;
        logic signed [63:0]         sa;
        logic signed [63:0]         ca;
        logic signed [63:0]         c;
        logic signed [63:0]         s;
        int                         k;
        tab = '0;
        for (k = 0; k < SEGMENTS; k++) begin
            oct = 64'(8 * k) / SEG_COUNT;
            rem = 64'(8 * k) - oct * SEG_COUNT;
            if (!oct[0]) begin
                x  = (PI_QUARTER_Q32 * rem) / ANGLE_DIV;
                sa = to_trig_bits(sin_q30(x));
                ca = to_trig_bits(cos_q30(x));
            end else begin
                x  = (PI_QUARTER_Q32 * (SEG_COUNT - rem)) / ANGLE_DIV;
                sa = to_trig_bits(cos_q30(x));
                ca = to_trig_bits(sin_q30(x));
            end
            case (oct[2:1])
                2'd0: begin
                    c = ca;
                    s = sa;
                end
                2'd1: begin
                    c = -sa;
                    s = ca;
                end
                2'd2: begin
                    c = -ca;
                    s = -sa;
                end
                default: begin
                    c = sa;
                    s = -ca;
                end
            endcase
            tab[k*TRIG_W +: TRIG_W] = want_sin ? s[TRIG_W-1:0] : c[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [SEGMENTS*TRIG_W-1:0] COS_TAB = build_trig(1'b0);
    localparam logic [SEGMENTS*TRIG_W-1:0] SIN_TAB = build_trig(1'b1);

endpackage

@@ hdl/circle_outline_segment_generator.sv @@
// Top level: configuration registers, frame sequencer and command output register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_in_item         | frame tick in
//  out     | o_out_valid, i_out_ready, o_out_item      | draw command out
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data| register write in
//
// A filled-mode frame passes through S_START (after S_HUE with rainbow, the hue step) to
// S_OUT. In outline mode every polygon point passes S_MUL_X, S_SUM_X and S_SUM_Y through
// the one shared multiply unit (x then y) and each line adds its S_OUT state, which holds
// on output stalls. Disabled frames are accepted and produce nothing.
// Synchronous active-low reset; o_in_ready is low while a frame is being worked on,
// and the sequencer holds while o_out_valid waits on i_out_ready.
module circle_outline_segment_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cosg_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cosg_pkg::t_out_item   o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import cosg_pkg::*;

    // Control decoded from the state
    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic hue_advance;
        logic issue_x;
        logic issue_y;
    } t_ctrl;

    t_state                    r_state;
    t_state                    n_state;
    t_ctrl                     w_ctrl;

    logic                      r_enable;
    logic                      r_outline;
    logic                      r_rainbow;
    logic [RADIUS_W-1:0]       r_radius;
    logic [THICK_W-1:0]        r_thick;
    logic [31:0]               r_base;
    logic [15:0]               r_step;

    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_nx;
    logic [31:0]               r_color;
    logic [SEG_CNT_W-1:0]      r_k;
    t_out_item                 r_out;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic                      w_last_seg;
    logic [SEG_IDX_W-1:0]      w_idx;
    logic signed [TRIG_W-1:0]  w_cos;
    logic signed [TRIG_W-1:0]  w_sin;
    t_pt_req                   w_req;
    logic signed [COORD_W-1:0] w_coord;
    logic [23:0]               w_rgb;
    logic [31:0]               w_color;
    logic [THICK_W-1:0]        w_thick;

    assign w_in_acc   = i_in_valid && w_ctrl.in_ready;
    assign w_out_acc  = w_ctrl.out_valid && i_out_ready;
    assign w_last_seg = (r_k == SEG_CNT_W'(SEGMENTS));

    assign o_in_ready  = w_ctrl.in_ready;
    assign o_out_valid = w_ctrl.out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_outline <= 1'b0;
            r_rainbow <= 1'b0;
            r_radius  <= RADIUS_W'(160);
            r_thick   <= THICK_W'(16);
            r_base    <= 32'hFFFF_FFFF;
            r_step    <= 16'd131;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE:    r_enable  <= i_cfg_data[0];
                CFG_OUTLINE:   r_outline <= i_cfg_data[0];
                CFG_RAINBOW:   r_rainbow <= i_cfg_data[0];
                CFG_RADIUS:    r_radius  <= i_cfg_data[RADIUS_W-1:0];
                CFG_THICKNESS: r_thick   <= i_cfg_data[THICK_W-1:0];
                CFG_COLOR:     r_base    <= i_cfg_data;
                CFG_HUE_STEP:  r_step    <= i_cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_enable) begin
                    n_state = r_rainbow ? S_HUE : S_START;
                end
            end
            S_HUE:   n_state = S_START;
            S_START: n_state = r_outline ? S_MUL_X : S_OUT;
            S_MUL_X: n_state = S_SUM_X;
            S_SUM_X: n_state = S_SUM_Y;
            S_SUM_Y: n_state = (r_k == '0) ? S_MUL_X : S_OUT;
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = (r_out.last_command) ? S_IDLE : S_MUL_X;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State decode
    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            S_IDLE:  w_ctrl.in_ready    = 1'b1;
            S_HUE:   w_ctrl.hue_advance = 1'b1;
            S_MUL_X: w_ctrl.issue_x     = 1'b1;
            S_SUM_X: w_ctrl.issue_y     = 1'b1;
            S_OUT:   w_ctrl.out_valid   = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Angle index wraps back to entry 0 for the closing point
    assign w_idx = w_last_seg ? '0 : r_k[SEG_IDX_W-1:0];
    assign w_cos = COS_TAB[int'(w_idx)*TRIG_W +: TRIG_W];
    assign w_sin = SIN_TAB[int'(w_idx)*TRIG_W +: TRIG_W];

    always_comb begin
        w_req.issue  = w_ctrl.issue_x || w_ctrl.issue_y;
        w_req.trig   = w_ctrl.issue_y ? w_sin : w_cos;
        w_req.center = w_ctrl.issue_y ? r_cy : r_cx;
    end

    cosg_point_unit u_point (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_radius (r_radius),
        .o_coord  (w_coord)
    );

    cosg_hue_unit u_hue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_ctrl.hue_advance),
        .i_step    (r_step),
        .o_rgb     (w_rgb)
    );

    assign w_color = r_rainbow ? {r_base[31:24], w_rgb} : r_base;
    assign w_thick = (r_thick < THICK_MIN) ? THICK_MIN : r_thick;

    // Frame datapath and output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cx <= i_in_item.center_x;
            r_cy <= i_in_item.center_y;
        end
        if (r_state == S_START) begin
            r_color <= w_color;
            r_k     <= '0;
            if (!r_outline) begin
                r_out.command_kind <= CMD_CIRCLE;
                r_out.start_x      <= r_cx;
                r_out.start_y      <= r_cy;
                r_out.delta_x      <= '0;
                r_out.delta_y      <= '0;
                r_out.draw_size    <= r_radius;
                r_out.draw_color   <= w_color;
                r_out.last_command <= 1'b1;
            end
        end
        if (r_state == S_SUM_X) begin
            r_nx <= w_coord;
        end
        if (r_state == S_SUM_Y) begin
            r_px <= r_nx;
            r_py <= w_coord;
            if (r_k == '0) begin
                r_k <= SEG_CNT_W'(1);
            end else begin
                r_out.command_kind <= CMD_LINE;
                r_out.start_x      <= r_px;
                r_out.start_y      <= r_py;
                r_out.delta_x      <= sat_coord(SUM_W'(r_nx) - SUM_W'(r_px));
                r_out.delta_y      <= sat_coord(SUM_W'(w_coord) - SUM_W'(r_py));
                r_out.draw_size    <= RADIUS_W'(w_thick);
                r_out.draw_color   <= r_color;
                r_out.last_command <= w_last_seg;
            end
        end
        if (w_out_acc && !r_out.last_command) begin
            r_k <= r_k + SEG_CNT_W'(1);
        end
    end

endmodule

@@ hdl/cosg_point_unit.sv @@
// Shared point unit: trig times radius, rounded, added to the centre and saturated.
module cosg_point_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cosg_pkg::t_pt_req                   i_req,
    input  logic [cosg_pkg::RADIUS_W-1:0]       i_radius,
    output logic signed [cosg_pkg::COORD_W-1:0] o_coord
);
    import cosg_pkg::*;

    logic signed [PROD_W-1:0]         r_prod;
    logic signed [COORD_W-1:0]        r_center;
    logic signed [PROD_W-1:0]         n_prod;
    logic signed [PROD_W-1:0]         w_rounded;
    logic signed [PROD_W-TRIG_FRACTION_BITS-1:0] w_offset;
    logic signed [SUM_W-1:0]          w_sum;

    // Multiply stage
    assign n_prod = PROD_W'(i_req.trig) * PROD_W'($signed({1'b0, i_radius}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod   <= '0;
            r_center <= '0;
        end else if (i_req.issue) begin
            r_prod   <= n_prod;
            r_center <= i_req.center;
        end
    end

    // Round half up, floor shift, add centre, saturate
    assign w_rounded = r_prod + PROD_W'(1 << (TRIG_FRACTION_BITS - 1));
    assign w_offset  = w_rounded[PROD_W-1:TRIG_FRACTION_BITS];
    assign w_sum     = SUM_W'(r_center) + SUM_W'(w_offset);
    assign o_coord   = sat_coord(w_sum);

endmodule

@@ hdl/cosg_hue_unit.sv @@
// Hue accumulator and hue to RGB conversion at full saturation and value.
module cosg_hue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_advance,
    input  logic [15:0] i_step,
    output logic [23:0] o_rgb
);
    import cosg_pkg::*;

    logic [15:0] r_hue;
    logic [18:0] w_h6;
    logic [2:0]  w_sector;
    logic [15:0] w_frac;
    logic [16:0] w_rest;
    logic [23:0] w_up_full;
    logic [24:0] w_dn_full;
    logic [7:0]  w_up;
    logic [7:0]  w_dn;

    // Hue phase wraps once per turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue <= '0;
        end else if (i_advance) begin
            r_hue <= r_hue + i_step;
        end
    end

    // Sector and fraction: hue * 6
    assign w_h6      = {1'b0, r_hue, 2'b00} + {2'b00, r_hue, 1'b0};
    assign w_sector  = w_h6[18:16];
    assign w_frac    = w_h6[15:0];
    assign w_rest    = 17'h10000 - {1'b0, w_frac};
    // x * 255 as x * 256 - x
    assign w_up_full = {w_frac, 8'h00} - {8'h00, w_frac};
    assign w_dn_full = {w_rest, 8'h00} - {8'h00, w_rest};
    assign w_up      = w_up_full[23:16];
    assign w_dn      = w_dn_full[23:16];

    always_comb begin
        unique case (w_sector)
            3'd0:    o_rgb = {8'hFF, w_up, 8'h00};
            3'd1:    o_rgb = {w_dn, 8'hFF, 8'h00};
            3'd2:    o_rgb = {8'h00, 8'hFF, w_up};
            3'd3:    o_rgb = {8'h00, w_dn, 8'hFF};
            3'd4:    o_rgb = {w_up, 8'h00, 8'hFF};
            default: o_rgb = {8'hFF, 8'h00, w_dn};
        endcase
    end

endmodule
